@@ design/dtrf_pkg.sv @@
`default_nettype none

package dtrf_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned XID_W       = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // request opcodes, carried on in_tuser
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_COLLECT = 2'd1;
  localparam logic [1:0] OP_MARK    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_HEAP_MGR  = 2'd0;
  localparam logic [1:0] CFG_DEL_KIND  = 2'd1;
  localparam logic [1:0] CFG_NOOP_MGR  = 2'd2;
  localparam logic [1:0] CFG_NOOP_INFO = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_t;

  // lookup token that walks down the row of cells
  typedef struct packed {
    logic             vld;
    logic [XID_W-1:0] key_a;
    logic [XID_W-1:0] key_b;
    logic             hit_a;
    logic             hit_b;
  } tok_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             wr;
    logic [CNT_W-1:0] count;
    logic [XID_W-1:0] data;
  } cell_ctl_t;

  function automatic logic [IDX_W-1:0] idx_of(input int unsigned k);
    logic [31:0] kv;
    kv = k;
    return kv[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/dtrf_cell.sv @@
`default_nettype none

module dtrf_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [dtrf_pkg::IDX_W-1:0] cell_idx,
  input  wire dtrf_pkg::cell_ctl_t     ctl,
  input  wire dtrf_pkg::tok_t          tok_in,
  output dtrf_pkg::tok_t               tok_out
);

  logic [dtrf_pkg::XID_W-1:0] entry_r;
  logic [dtrf_pkg::CNT_W-1:0] idx_ext;
  logic                       occupied;
  logic                       sel;
  dtrf_pkg::tok_t             tok_r;
  dtrf_pkg::tok_t             tok_nxt;

  assign idx_ext  = {1'b0, cell_idx};
  assign occupied = idx_ext < ctl.count;
  assign sel      = ctl.wr && (idx_ext == ctl.count);

  always_ff @(posedge clk) begin
    if (sel) begin
      entry_r <= ctl.data;
    end
  end

  always_comb begin
    tok_nxt       = tok_in;
    tok_nxt.hit_a = tok_in.hit_a | (occupied && (entry_r == tok_in.key_a));
    tok_nxt.hit_b = tok_in.hit_b | (occupied && (entry_r == tok_in.key_b));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

@@ design/delete_txn_record_filter.sv @@
`default_nettype none

// Delete-record filter. Each request (opcode on in_tuser) yields exactly one
// result. Clear empties the id table; collect records that are heap deletes
// with a body insert their deleting xid unless already present or the table
// is full; mark records are rewritten to the no-op manager id and info byte
// when they are deletes or their record or top-level xid is in the table.
// The table is a row of TABLE_DEPTH cells, one id each, and a lookup token
// moves one cell per clock. Requests are handled one at a time: a lookup
// (collect with a delete body, or mark of a non-delete record) launches a
// token through launch_r and every cell; its flags are registered, then S_EMIT
// follows. Other requests go to S_EMIT directly, which registers the result
// once no earlier one waits on out_tready. A new request is taken while
// the previous result still waits on out_tready. Configuration must be
// written only while no request is in flight; the block does not enforce it.

module delete_txn_record_filter (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // manager_id[7:0], info_bits[15:8], record_xid[47:16], top_xid[79:48],
  // deleted_xmax[111:80], has_delete_body[112], zero[119:113]
  input  wire logic [119:0] in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_manager_id[7:0], out_info_bits[15:8], marked[16], inserted[17],
  // table_full[18], zero[23:19]
  output logic [23:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [7:0]   cfg_wdata
);

  localparam int unsigned Depth = dtrf_pkg::TABLE_DEPTH;

  // configuration
  logic [7:0] heap_mgr_r;
  logic [2:0] del_kind_r;
  logic [7:0] noop_mgr_r;
  logic [7:0] noop_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_mgr_r  <= 8'd10;
      del_kind_r  <= 3'd1;
      noop_mgr_r  <= 8'd0;
      noop_info_r <= 8'd32;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dtrf_pkg::CFG_HEAP_MGR:  heap_mgr_r  <= cfg_wdata;
        dtrf_pkg::CFG_DEL_KIND:  del_kind_r  <= cfg_wdata[2:0];
        dtrf_pkg::CFG_NOOP_MGR:  noop_mgr_r  <= cfg_wdata;
        dtrf_pkg::CFG_NOOP_INFO: noop_info_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input fields
  logic [1:0]                 in_op;
  logic [7:0]                 in_mgr;
  logic [7:0]                 in_info;
  logic [dtrf_pkg::XID_W-1:0] in_rxid;
  logic [dtrf_pkg::XID_W-1:0] in_txid;
  logic [dtrf_pkg::XID_W-1:0] in_xmax;
  logic                       in_body;
  logic                       in_is_del;
  logic                       need_walk;

  assign in_op     = in_tuser;
  assign in_mgr    = in_tdata[7:0];
  assign in_info   = in_tdata[15:8];
  assign in_rxid   = in_tdata[47:16];
  assign in_txid   = in_tdata[79:48];
  assign in_xmax   = in_tdata[111:80];
  assign in_body   = in_tdata[112];
  assign in_is_del = (in_mgr == heap_mgr_r) && (in_info[6:4] == del_kind_r);
  assign need_walk = ((in_op == dtrf_pkg::OP_COLLECT) && in_is_del && in_body) ||
                     ((in_op == dtrf_pkg::OP_MARK) && !in_is_del);

  // sequencer
  dtrf_pkg::state_t state_r;
  dtrf_pkg::state_t state_nxt;
  logic             acc;
  logic             walk_done;
  logic             emit_go;
  logic             out_valid_r;

  dtrf_pkg::tok_t   chain [0:Depth];
  dtrf_pkg::tok_t   launch_r;
  dtrf_pkg::tok_t   chain_out;

  assign chain_out = chain[Depth];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtrf_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = need_walk ? dtrf_pkg::S_WALK : dtrf_pkg::S_EMIT;
        end
      end
      dtrf_pkg::S_WALK: begin
        if (chain_out.vld) begin
          state_nxt = dtrf_pkg::S_EMIT;
        end
      end
      dtrf_pkg::S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = dtrf_pkg::S_IDLE;
        end
      end
      default: state_nxt = dtrf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    walk_done = 1'b0;
    emit_go   = 1'b0;
    unique case (state_r)
      dtrf_pkg::S_IDLE: in_tready = 1'b1;
      dtrf_pkg::S_WALK: walk_done = chain_out.vld;
      dtrf_pkg::S_EMIT: emit_go   = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtrf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // held request
  logic [1:0]                 op_r;
  logic [7:0]                 mgr_r;
  logic [7:0]                 info_r;
  logic [dtrf_pkg::XID_W-1:0] xmax_r;
  logic                       is_del_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r     <= in_op;
      mgr_r    <= in_mgr;
      info_r   <= in_info;
      xmax_r   <= in_xmax;
      is_del_r <= in_is_del;
    end
  end

  // launch a single-cycle token into the first cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= '0;
    end else begin
      launch_r.vld   <= acc && need_walk;
      launch_r.key_a <= (in_op == dtrf_pkg::OP_MARK) ? in_rxid : in_xmax;
      launch_r.key_b <= (in_op == dtrf_pkg::OP_MARK) ? in_txid : in_xmax;
      launch_r.hit_a <= 1'b0;
      launch_r.hit_b <= 1'b0;
    end
  end

  // table occupancy and insert
  logic [dtrf_pkg::CNT_W-1:0] count_r;
  logic                       found;
  logic                       ins;
  logic                       drop;
  logic                       hit_r;
  logic                       ins_r;
  logic                       full_r;
  dtrf_pkg::cell_ctl_t        ctl;

  assign found = chain_out.hit_a | chain_out.hit_b;
  assign ins   = walk_done && (op_r == dtrf_pkg::OP_COLLECT) && !found &&
                 (count_r < dtrf_pkg::DEPTH_CNT);
  assign drop  = walk_done && (op_r == dtrf_pkg::OP_COLLECT) && !found &&
                 (count_r >= dtrf_pkg::DEPTH_CNT);

  assign ctl.wr    = ins;
  assign ctl.count = count_r;
  assign ctl.data  = xmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc && (in_op == dtrf_pkg::OP_CLEAR)) begin
      count_r <= '0;
    end else if (ins) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hit_r  <= 1'b0;
      ins_r  <= 1'b0;
      full_r <= 1'b0;
    end else if (walk_done) begin
      hit_r  <= found;
      ins_r  <= ins;
      full_r <= drop;
    end
  end

  assign chain[0] = launch_r;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    dtrf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (dtrf_pkg::idx_of(k)),
      .ctl      (ctl),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1])
    );
  end

  // result
  logic [7:0]  res_mgr;
  logic [7:0]  res_info;
  logic        res_marked;
  logic [23:0] out_data_r;

  always_comb begin
    res_mgr    = 8'd0;
    res_info   = 8'd0;
    res_marked = 1'b0;
    unique case (op_r)
      dtrf_pkg::OP_COLLECT: begin
        res_mgr  = mgr_r;
        res_info = info_r;
      end
      dtrf_pkg::OP_MARK: begin
        res_marked = is_del_r | hit_r;
        res_mgr    = res_marked ? noop_mgr_r : mgr_r;
        res_info   = res_marked ? noop_info_r : info_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r <= {5'd0,
                     (op_r == dtrf_pkg::OP_COLLECT) && full_r,
                     (op_r == dtrf_pkg::OP_COLLECT) && ins_r,
                     res_marked, res_info, res_mgr};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
